### rtl/abrf_pkg.sv
// ----------------------------------------------------------------------------
// abrf_pkg
// Shared types and constants of the alpha-blended rectangle fill block.
// ----------------------------------------------------------------------------
package abrf_pkg;

	localparam int COORD_W = 13;
	localparam int SIZE_W  = 12;
	localparam int CLIP_W  = 14;
	localparam int CHAN_W  = 8;
	localparam int COUNT_W = 17;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;

	localparam logic [1:0] ACT_DRAW = 2'd0;
	localparam logic [1:0] ACT_FILL = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SIZE_W-1:0]         size_t;
	typedef logic [CHAN_W-1:0]         chan_t;
	typedef logic [COUNT_W-1:0]        count_t;

	typedef struct packed {
		chan_t alpha;
		chan_t blue;
		chan_t green;
		chan_t red;
	} color_t;

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_SETUP  = 9'b000000100,
		ST_START  = 9'b000001000,
		ST_WALK   = 9'b000010000,
		ST_DRAIN  = 9'b000100000,
		ST_READ   = 9'b001000000,
		ST_RDWAIT = 9'b010000000,
		ST_FINISH = 9'b100000000
	} state_t;

endpackage

### rtl/abrf_if.sv
// ----------------------------------------------------------------------------
// abrf_req_if / abrf_rsp_if
// Valid/ready channels carrying draw requests and their responses.
// ----------------------------------------------------------------------------
interface abrf_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          action;
	abrf_pkg::coord_t    pos_x;
	abrf_pkg::coord_t    pos_y;
	abrf_pkg::size_t     rect_width;
	abrf_pkg::size_t     rect_height;
	abrf_pkg::chan_t     color_red;
	abrf_pkg::chan_t     color_green;
	abrf_pkg::chan_t     color_blue;
	abrf_pkg::chan_t     color_alpha;

	modport source (
		output valid, action, pos_x, pos_y, rect_width, rect_height,
		       color_red, color_green, color_blue, color_alpha,
		input  ready
	);
	modport sink (
		input  valid, action, pos_x, pos_y, rect_width, rect_height,
		       color_red, color_green, color_blue, color_alpha,
		output ready
	);
endinterface

interface abrf_rsp_if;
	logic                valid;
	logic                ready;
	abrf_pkg::chan_t     pixel_red;
	abrf_pkg::chan_t     pixel_green;
	abrf_pkg::chan_t     pixel_blue;
	abrf_pkg::chan_t     pixel_alpha;
	abrf_pkg::count_t    pixels_drawn;

	modport source (
		output valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, pixels_drawn,
		input  ready
	);
	modport sink (
		input  valid, pixel_red, pixel_green, pixel_blue, pixel_alpha, pixels_drawn,
		output ready
	);
endinterface

### rtl/abrf_blend.sv
// ----------------------------------------------------------------------------
// abrf_blend
// Two-stage read-modify-write: products, divide by 255, write; opaque bypasses.
// ----------------------------------------------------------------------------
module abrf_blend #(
	parameter int AW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             issue,
	input  logic [AW-1:0]    issue_addr,
	input  logic [31:0]      rdata,
	input  abrf_pkg::color_t color,
	output logic             busy,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output logic [31:0]      wr_data
);
	import abrf_pkg::*;

	logic          v_s1;
	logic [AW-1:0] addr_s1;
	logic          v_s2;
	logic [AW-1:0] addr_s2;
	logic [15:0]   pr_src_s2, pg_src_s2, pb_src_s2;
	logic [15:0]   pr_bg_s2, pg_bg_s2, pb_bg_s2;
	chan_t         alpha_s2;
	chan_t         inv_a;
	logic          opaque;

	// exact floor(s/255) for s < 65280
	function automatic chan_t div255(input logic [15:0] s);
		logic [16:0] t;
		t = 17'(s) + 17'd1 + 17'(s >> 8);
		return t[15:8];
	endfunction

	assign inv_a  = ALPHA_OPAQUE - color.alpha;
	assign opaque = (color.alpha == ALPHA_OPAQUE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1   <= issue_addr;
		addr_s2   <= addr_s1;
		alpha_s2  <= rdata[31:24];
		pr_src_s2 <= 16'(color.red)   * 16'(color.alpha);
		pg_src_s2 <= 16'(color.green) * 16'(color.alpha);
		pb_src_s2 <= 16'(color.blue)  * 16'(color.alpha);
		pr_bg_s2  <= 16'(rdata[7:0])   * 16'(inv_a);
		pg_bg_s2  <= 16'(rdata[15:8])  * 16'(inv_a);
		pb_bg_s2  <= 16'(rdata[23:16]) * 16'(inv_a);
	end

	assign busy    = v_s1 | v_s2;
	assign wr_en   = v_s2;
	assign wr_addr = addr_s2;
	assign wr_data = opaque ? color :
		{alpha_s2, div255(pb_src_s2 + pb_bg_s2), div255(pg_src_s2 + pg_bg_s2),
		 div255(pr_src_s2 + pr_bg_s2)};

endmodule

### rtl/alpha_blend_rect_fill.sv
// One request is in work at a time; a fill walks each on-screen pixel it covers, and
// the next request is taken only after the response is loaded. A held response stalls
// the block at finish.
// Reset: drawing is disabled and a clearing pass writes zero to all
// SCREEN_WIDTH*SCREEN_HEIGHT words, one a cycle, before the first request is taken.
// ----------------------------------------------------------------------------
// alpha_blend_rect_fill
// RGBA frame store with pixel draw, alpha-blended rectangle fill and pixel read.
// ----------------------------------------------------------------------------
module alpha_blend_rect_fill #(
	parameter int SCREEN_WIDTH  = 256,
	parameter int SCREEN_HEIGHT = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	abrf_req_if.sink   req,
	abrf_rsp_if.source rsp
);
	import abrf_pkg::*;

	localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [CLIP_W-1:0] WS = CLIP_W'(SCREEN_WIDTH);
	localparam logic signed [CLIP_W-1:0] HS = CLIP_W'(SCREEN_HEIGHT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [AW-1:0] STRIDE    = AW'(SCREEN_WIDTH);

	state_t state_q;
	logic   en_q;

	logic [1:0] act_q;
	coord_t     x_q, y_q;
	size_t      w_q, h_q;
	color_t     color_q;

	logic [SIZE_W-1:0]        x0_q, y0_q;
	logic signed [CLIP_W-1:0] x1c_q, y1c_q;
	logic                     void_q;

	logic [SIZE_W-1:0] px_q, py_q, xl_q, yl_q;
	logic [AW-1:0]     addr_q, row_addr_q, clr_q;
	count_t            cnt_q;
	logic [31:0]       res_pix_q;

	logic          rsp_valid_q;
	logic [31:0]   rsp_pix_q;
	count_t        rsp_cnt_q;

	logic [31:0]   mem [DEPTH];
	logic [31:0]   rdata_q;

	logic                     issue;
	logic                     busy;
	logic                     bl_we;
	logic [AW-1:0]            bl_waddr;
	logic [31:0]              bl_wdata;
	logic                     mem_we;
	logic [AW-1:0]            mem_waddr;
	logic [31:0]              mem_wdata;
	logic signed [CLIP_W-1:0] xs, ys, ws, hs, x1, y1;
	logic [AW-1:0]            start_addr;
	logic                     empty;
	logic                     rsp_load;

	assign req.ready = (state_q == ST_IDLE);
	assign issue     = (state_q == ST_WALK);
	assign rsp_load  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	// clip window; draw and read act as a one-pixel rectangle
	always_comb begin
		xs = CLIP_W'(x_q);
		ys = CLIP_W'(y_q);
		ws = (act_q == ACT_FILL) ? $signed({2'b00, w_q}) : CLIP_W'(1);
		hs = (act_q == ACT_FILL) ? $signed({2'b00, h_q}) : CLIP_W'(1);
		x1 = xs + ws;
		y1 = ys + hs;
	end

	assign start_addr = AW'(32'(y0_q) * 32'(SCREEN_WIDTH)) + AW'(x0_q);
	assign empty = void_q || ($signed({2'b00, x0_q}) >= x1c_q) ||
		($signed({2'b00, y0_q}) >= y1c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			en_q        <= 1'b0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				en_q <= cfg_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					state_q <= ST_START;
				end
				ST_START: begin
					if (empty) begin
						state_q <= ST_FINISH;
					end else if (act_q == ACT_READ) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (px_q == xl_q && py_q == yl_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			act_q   <= req.action;
			x_q     <= req.pos_x;
			y_q     <= req.pos_y;
			w_q     <= req.rect_width;
			h_q     <= req.rect_height;
			color_q <= '{alpha: req.color_alpha, blue: req.color_blue,
				green: req.color_green, red: req.color_red};
		end
		if (state_q == ST_SETUP) begin
			x0_q   <= x_q[COORD_W-1] ? '0 : x_q[SIZE_W-1:0];
			y0_q   <= y_q[COORD_W-1] ? '0 : y_q[SIZE_W-1:0];
			x1c_q  <= (x1 > WS) ? WS : x1;
			y1c_q  <= (y1 > HS) ? HS : y1;
			void_q <= (act_q != ACT_READ) && (act_q != ACT_FILL) && (act_q != ACT_DRAW) ||
				(act_q != ACT_READ) && !en_q;
		end
		if (state_q == ST_START) begin
			addr_q     <= start_addr;
			row_addr_q <= start_addr;
			px_q       <= x0_q;
			py_q       <= y0_q;
			xl_q       <= SIZE_W'(x1c_q - CLIP_W'(1));
			yl_q       <= SIZE_W'(y1c_q - CLIP_W'(1));
			cnt_q      <= '0;
			res_pix_q  <= '0;
		end
		if (issue) begin
			if (cnt_q != COUNT_MAX) begin
				cnt_q <= cnt_q + count_t'(1);
			end
			if (px_q == xl_q) begin
				px_q       <= x0_q;
				py_q       <= py_q + SIZE_W'(1);
				row_addr_q <= row_addr_q + STRIDE;
				addr_q     <= row_addr_q + STRIDE;
			end else begin
				px_q   <= px_q + SIZE_W'(1);
				addr_q <= addr_q + AW'(1);
			end
		end
		if (state_q == ST_RDWAIT) begin
			res_pix_q <= rdata_q;
		end
		if (rsp_load) begin
			rsp_pix_q <= res_pix_q;
			rsp_cnt_q <= cnt_q;
		end
	end

	abrf_blend #(
		.AW(AW)
	) u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.issue_addr (addr_q),
		.rdata      (rdata_q),
		.color      (color_q),
		.busy       (busy),
		.wr_en      (bl_we),
		.wr_addr    (bl_waddr),
		.wr_data    (bl_wdata)
	);

	assign mem_we    = (state_q == ST_CLEAR) || bl_we;
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : bl_waddr;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : bl_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[addr_q];
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.pixel_red    = rsp_pix_q[7:0];
	assign rsp.pixel_green  = rsp_pix_q[15:8];
	assign rsp.pixel_blue   = rsp_pix_q[23:16];
	assign rsp.pixel_alpha  = rsp_pix_q[31:24];
	assign rsp.pixels_drawn = rsp_cnt_q;

`ifndef SYNTHESIS
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !busy)
		else $error("blend pipeline active during clearing pass");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !busy)
		else $error("response formed before writes retired");

	a_walk_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (addr_q <= LAST_ADDR))
		else $error("fill address beyond frame store");

	a_draw_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.pixels_drawn != '0) |-> (rsp_pix_q == '0))
		else $error("draw response carries pixel data");

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_SETUP))
		else $error("accepted request not taken into setup");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alpha-blended rectangle fill block. Requests go
// in from a queue through a clocked driver. Every accepted request is applied
// to a local copy of the frame store, which gives the expected response. A
// clocked monitor compares each response field by field. Directed requests
// come first, then random phases with drawing on and off.
// ----------------------------------------------------------------------------
module testbench;
	import abrf_pkg::*;

	localparam int SCREEN_W = 256;
	localparam int SCREEN_H = 256;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] action;
		coord_t     pos_x;
		coord_t     pos_y;
		size_t      rect_width;
		size_t      rect_height;
		chan_t      color_red;
		chan_t      color_green;
		chan_t      color_blue;
		chan_t      color_alpha;
	} draw_req_t;

	typedef struct packed {
		chan_t  red;
		chan_t  green;
		chan_t  blue;
		chan_t  alpha;
		count_t drawn;
	} pixel_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	abrf_req_if req_ch ();
	abrf_rsp_if rsp_ch ();

	alpha_blend_rect_fill #(
		.SCREEN_WIDTH  (SCREEN_W),
		.SCREEN_HEIGHT (SCREEN_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.rsp         (rsp_ch)
	);

	color_t     shadow_fb [SCREEN_W*SCREEN_H];
	bit         draw_en;
	bit         steady;
	int         errors;
	draw_req_t  cmd_queue [$];
	pixel_rsp_t rsp_due [$];
	draw_req_t  on_bus;
	pixel_rsp_t rsp_head;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Verification failed");
		$finish;
	end

	task automatic flag(string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic compare(string field, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag($sformatf("%s: got %0d, expected %0d", field, got, want));
	endtask

	function automatic bit onscreen(int x, int y);
		return x >= 0 && y >= 0 && x < SCREEN_W && y < SCREEN_H;
	endfunction

	function automatic chan_t mix(chan_t src, chan_t bg, chan_t a);
		int unsigned t;
		t = int'(src) * int'(a) + int'(bg) * (255 - int'(a));
		return chan_t'(t / 255);
	endfunction

	function automatic void plot(int x, int y, draw_req_t q);
		int     idx;
		color_t old;
		idx = y * SCREEN_W + x;
		if (q.color_alpha == ALPHA_OPAQUE) begin
			shadow_fb[idx] = {q.color_alpha, q.color_blue, q.color_green, q.color_red};
		end else begin
			old = shadow_fb[idx];
			old.red   = mix(q.color_red, old.red, q.color_alpha);
			old.green = mix(q.color_green, old.green, q.color_alpha);
			old.blue  = mix(q.color_blue, old.blue, q.color_alpha);
			shadow_fb[idx] = old;
		end
	endfunction

	// applies one request to the shadow frame store and returns its response
	function automatic pixel_rsp_t render(draw_req_t q);
		pixel_rsp_t res;
		color_t     pix;
		int         xs, ys, x0, y0, x1, y1;
		res = '0;
		xs = int'(q.pos_x);
		ys = int'(q.pos_y);
		case (q.action)
			ACT_DRAW: begin
				if (draw_en && onscreen(xs, ys)) begin
					plot(xs, ys, q);
					res.drawn = count_t'(1);
				end
			end
			ACT_FILL: begin
				if (draw_en && q.rect_width != 0 && q.rect_height != 0) begin
					x0 = xs < 0 ? 0 : xs;
					y0 = ys < 0 ? 0 : ys;
					x1 = xs + int'(q.rect_width);
					y1 = ys + int'(q.rect_height);
					if (x1 > SCREEN_W)
						x1 = SCREEN_W;
					if (y1 > SCREEN_H)
						y1 = SCREEN_H;
					for (int py = y0; py < y1; py++) begin
						for (int px = x0; px < x1; px++) begin
							plot(px, py, q);
							if (res.drawn != COUNT_MAX)
								res.drawn++;
						end
					end
				end
			end
			ACT_READ: begin
				if (onscreen(xs, ys)) begin
					pix = shadow_fb[ys * SCREEN_W + xs];
					res.red   = pix.red;
					res.green = pix.green;
					res.blue  = pix.blue;
					res.alpha = pix.alpha;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic draw_req_t req_of(logic [1:0] act, int x, int y, int w, int h,
			int r, int g, int b, int a);
		draw_req_t q;
		q.action      = act;
		q.pos_x       = x[COORD_W-1:0];
		q.pos_y       = y[COORD_W-1:0];
		q.rect_width  = w[SIZE_W-1:0];
		q.rect_height = h[SIZE_W-1:0];
		q.color_red   = r[CHAN_W-1:0];
		q.color_green = g[CHAN_W-1:0];
		q.color_blue  = b[CHAN_W-1:0];
		q.color_alpha = a[CHAN_W-1:0];
		return q;
	endfunction

	function automatic draw_req_t random_req();
		draw_req_t   q;
		int unsigned pick;
		int unsigned corner;
		pick = $urandom_range(99);
		q.action = pick < 35 ? ACT_DRAW : pick < 65 ? ACT_FILL : pick < 95 ? ACT_READ : ACT_NONE;
		pick = $urandom_range(99);
		if (pick < 50) begin
			// small hot spots so reads land on pixels drawn before
			corner = $urandom_range(1) ? 240 : 0;
			q.pos_x = coord_t'($urandom_range(15) + corner);
			q.pos_y = coord_t'($urandom_range(15) + corner);
		end else if (pick < 80) begin
			q.pos_x = coord_t'($urandom_range(SCREEN_W - 1));
			q.pos_y = coord_t'($urandom_range(SCREEN_H - 1));
		end else begin
			q.pos_x = coord_t'($urandom);
			q.pos_y = coord_t'($urandom);
		end
		q.rect_width  = size_t'($urandom);
		q.rect_height = size_t'($urandom);
		if (q.action == ACT_FILL) begin
			pick = $urandom_range(999);
			if (pick < 750) begin
				q.rect_width  = size_t'($urandom_range(8));
				q.rect_height = size_t'($urandom_range(8));
			end else if (pick < 870) begin
				q.rect_height = size_t'($urandom_range(3));
			end else if (pick < 995) begin
				q.rect_width = size_t'($urandom_range(3));
			end
		end
		q.color_red   = chan_t'($urandom);
		q.color_green = chan_t'($urandom);
		q.color_blue  = chan_t'($urandom);
		pick = $urandom_range(99);
		q.color_alpha = pick < 25 ? ALPHA_OPAQUE : pick < 35 ? chan_t'(0) : chan_t'($urandom);
		return q;
	endfunction

	task automatic queue_random(int n);
		draw_req_t q;
		int        made;
		made = 0;
		while (made < n) begin
			q = random_req();
			cmd_queue.push_back(q);
			if (q.action != ACT_NONE)
				made++;
		end
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (cmd_queue.size() != 0 || req_ch.valid || rsp_due.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_draw(bit v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		draw_en = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				rsp_due.push_back(render(on_bus));
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_queue.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
					on_bus = cmd_queue.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.action      <= on_bus.action;
					req_ch.pos_x       <= on_bus.pos_x;
					req_ch.pos_y       <= on_bus.pos_y;
					req_ch.rect_width  <= on_bus.rect_width;
					req_ch.rect_height <= on_bus.rect_height;
					req_ch.color_red   <= on_bus.color_red;
					req_ch.color_green <= on_bus.color_green;
					req_ch.color_blue  <= on_bus.color_blue;
					req_ch.color_alpha <= on_bus.color_alpha;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due.size() == 0) begin
					flag("response with no request outstanding");
				end else begin
					rsp_head = rsp_due.pop_front();
					compare("pixel_red", 32'(rsp_ch.pixel_red), 32'(rsp_head.red));
					compare("pixel_green", 32'(rsp_ch.pixel_green), 32'(rsp_head.green));
					compare("pixel_blue", 32'(rsp_ch.pixel_blue), 32'(rsp_head.blue));
					compare("pixel_alpha", 32'(rsp_ch.pixel_alpha), 32'(rsp_head.alpha));
					compare("pixels_drawn", 32'(rsp_ch.pixels_drawn), 32'(rsp_head.drawn));
				end
			end
			rsp_ch.ready <= steady || $urandom_range(99) >= 9;
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = ACT_DRAW;
		req_ch.pos_x       = '0;
		req_ch.pos_y       = '0;
		req_ch.rect_width  = '0;
		req_ch.rect_height = '0;
		req_ch.color_red   = '0;
		req_ch.color_green = '0;
		req_ch.color_blue  = '0;
		req_ch.color_alpha = '0;
		rsp_ch.ready       = 1'b0;
		draw_en            = 1'b0;
		steady             = 1'b0;
		errors             = 0;
		foreach (shadow_fb[i])
			shadow_fb[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drawing still off from reset
		cmd_queue.push_back(req_of(ACT_DRAW, 0, 0, 0, 0, 1, 2, 3, 255));
		cmd_queue.push_back(req_of(ACT_FILL, 0, 0, 256, 256, 9, 9, 9, 255));
		cmd_queue.push_back(req_of(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();
		set_draw(1'b1);

		cmd_queue.push_back(req_of(ACT_DRAW, 0, 0, 0, 0, 'h12, 'h34, 'h56, 255));
		cmd_queue.push_back(req_of(ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_DRAW, 0, 0, 4095, 4095, 255, 0, 200, 128));
		cmd_queue.push_back(req_of(ACT_DRAW, 0, 0, 0, 0, 77, 88, 99, 0));
		cmd_queue.push_back(req_of(ACT_READ, 0, 0, 4095, 4095, 255, 255, 255, 255));
		cmd_queue.push_back(req_of(ACT_DRAW, 255, 255, 0, 0, 255, 255, 255, 255));
		cmd_queue.push_back(req_of(ACT_READ, 255, 255, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_DRAW, -1, 0, 0, 0, 5, 5, 5, 255));
		cmd_queue.push_back(req_of(ACT_DRAW, 256, 0, 0, 0, 5, 5, 5, 255));
		cmd_queue.push_back(req_of(ACT_DRAW, 0, -4096, 0, 0, 5, 5, 5, 255));
		cmd_queue.push_back(req_of(ACT_DRAW, 4095, 4095, 0, 0, 5, 5, 5, 255));
		cmd_queue.push_back(req_of(ACT_READ, -4096, -4096, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_READ, 4095, 0, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_FILL, 3, 3, 0, 10, 1, 1, 1, 255));
		cmd_queue.push_back(req_of(ACT_FILL, 3, 3, 10, 0, 1, 1, 1, 255));
		cmd_queue.push_back(req_of(ACT_FILL, -100, -100, 4095, 4095, 10, 200, 30, 255));
		cmd_queue.push_back(req_of(ACT_FILL, 0, 0, 256, 256, 250, 5, 128, 77));
		cmd_queue.push_back(req_of(ACT_FILL, 250, 250, 4095, 4095, 60, 70, 80, 200));
		cmd_queue.push_back(req_of(ACT_FILL, 4095, 0, 10, 10, 1, 1, 1, 255));
		cmd_queue.push_back(req_of(ACT_NONE, 7, 7, 3, 3, 1, 2, 3, 255));
		cmd_queue.push_back(req_of(ACT_READ, 128, 128, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_READ, 255, 0, 0, 0, 0, 0, 0, 0));
		cmd_queue.push_back(req_of(ACT_READ, 254, 254, 0, 0, 0, 0, 0, 0));
		drain();

		queue_random(600);
		drain();
		set_draw(1'b0);
		queue_random(200);
		drain();
		set_draw(1'b1);
		steady = 1'b1;
		queue_random(400);
		drain();
		steady = 1'b0;
		queue_random(400);
		drain();

		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
